[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the timing register select block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ATS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ATS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/ats_pkg.sv]
// ----------------------------------------------------------------------------
// ats_pkg
// Types, timing tables and constants of the ATA timing register select block.
// ----------------------------------------------------------------------------
`default_nettype none

package ats_pkg;

   // Request item fields.
   typedef struct packed {
      logic        op;
      logic        unit;
      logic [15:0] pio_modes;
      logic [15:0] pio_cycle_ns;
      logic [15:0] mwdma_modes;
      logic [15:0] mwdma_cycle_ns;
      logic [15:0] udma_modes;
      logic        dma_read;
   } req_type;

   // Result item fields.
   typedef struct packed {
      logic        status;
      logic [31:0] timing_word;
      logic [15:0] pio_cycle_used;
      logic [15:0] dma_cycle_used;
   } rsp_type;

   // Decoded and checked modes of a configure item.
   typedef struct packed {
      logic       reject;
      logic [2:0] pio_mode;
      logic [1:0] dma_mode;
      logic [2:0] udma_mode;
      logic       has_dma;
      logic       has_udma;
   } mode_info_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PIO_CLAMP,
      ST_PIO_SCAN,
      ST_DMA_CLAMP,
      ST_DMA_SCAN,
      ST_DONE
   } state_type;

   // Operation codes and register indexes.
   localparam logic OP_CONFIGURE   = 1'b0;
   localparam logic OP_FETCH       = 1'b1;
   localparam logic CSR_ULTRA_CELL = 1'b0;
   localparam logic CSR_CABLE_80   = 1'b1;

   localparam int PIO_ENTRIES = 11;
   localparam int DMA_ENTRIES = 9;
   localparam int IDX_W       = $clog2(PIO_ENTRIES);

   localparam logic [31:0] ULTRA_BIT        = 32'h0010_0000;
   localparam logic [31:0] ULTRA_READ_ADJ   = 32'h0080_0000;
   localparam logic [15:0] UDMA_OK_40       = 16'h0007;
   localparam logic [15:0] UDMA_OK_80       = 16'h001F;
   localparam logic [31:0] DMA_MODE0_BITS   = 32'h0008_4000;
   localparam logic [31:0] PIO_MODE0_BITS33 = 32'h0000_0526;
   localparam logic [31:0] PIO_MODE0_BITS66 = 32'h0000_038C;

   localparam logic [15:0] PIO_MIN_NS [5] = '{16'd600, 16'd383, 16'd240, 16'd180, 16'd120};
   localparam logic [15:0] DMA_MIN_NS [3] = '{16'd480, 16'd150, 16'd120};

   localparam logic [15:0] PIO_TIME [PIO_ENTRIES] = '{
      16'd2070, 16'd600, 16'd383, 16'd360, 16'd330, 16'd300,
      16'd270, 16'd240, 16'd239, 16'd180, 16'd120
   };
   localparam logic [31:0] PIO_BITS_33 [PIO_ENTRIES] = '{
      32'h0000_0400, 32'h0000_0526, 32'h0000_0085, 32'h0000_0046,
      32'h0000_0045, 32'h0000_0025, 32'h0000_0025, 32'h0000_0025,
      32'h0000_0025, 32'h0000_0025, 32'h0000_0025
   };
   localparam logic [31:0] PIO_BITS_66 [PIO_ENTRIES] = '{
      32'h0000_03FF, 32'h0000_038C, 32'h0000_020A, 32'h0000_018C,
      32'h0000_018A, 32'h0000_0156, 32'h0000_0148, 32'h0000_0127,
      32'h0000_0108, 32'h0000_00C6, 32'h0000_0065
   };

   localparam logic [15:0] DMA_TIME [DMA_ENTRIES] = '{
      16'd1950, 16'd480, 16'd360, 16'd270, 16'd240, 16'd210, 16'd180, 16'd150, 16'd120
   };
   localparam logic [31:0] DMA_BITS_33 [DMA_ENTRIES] = '{
      32'h0000_0000, 32'h0008_4000, 32'h0006_3000, 32'h0005_2800,
      32'h0004_2000, 32'h0004_1800, 32'h0003_1800, 32'h0002_1800,
      32'h0001_1800
   };
   localparam logic [31:0] DMA_BITS_66 [DMA_ENTRIES] = '{
      32'h000F_FC00, 32'h0008_4000, 32'h0006_3000, 32'h0004_A400,
      32'h0004_2000, 32'h0003_9C00, 32'h0003_1800, 32'h0002_9800,
      32'h0001_9400
   };

   localparam logic [31:0] UDMA_BITS_66 [5] = '{
      32'h1910_0000, 32'h14D0_0000, 32'h1090_0000, 32'h0C70_0000, 32'h0C50_0000
   };

   // Word that a unit holds after reset or after the cell type changes.
   function automatic logic [31:0] cell_word(input logic ultra);
      cell_word = (ultra ? PIO_MODE0_BITS66 : PIO_MODE0_BITS33) | DMA_MODE0_BITS;
   endfunction

   // Index of the highest set bit of a five-bit mode map, 0 when empty.
   function automatic logic [2:0] top_bit5(input logic [4:0] map);
      logic [2:0] n;
      n = 3'd0;
      for (int i = 0; i < 5; i++) begin
         if (map[i]) begin
            n = 3'(i);
         end
      end
      top_bit5 = n;
   endfunction

endpackage

`default_nettype wire

[design/ats_mode_check.sv]
// ----------------------------------------------------------------------------
// ats_mode_check
// Checks the mode bitmaps of a configure item and decodes the mode numbers.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_mode_check (
   input  ats_pkg::req_type       item,
   input  logic                   ultra_cell,
   input  logic                   cable_80,
   output ats_pkg::mode_info_type info
);
   import ats_pkg::*;

   logic [15:0] udma_ok;

   always_comb begin
      udma_ok = ultra_cell ? (cable_80 ? UDMA_OK_80 : UDMA_OK_40) : 16'h0000;

      // A PIO map must have a mode in 0..4 and nothing above mode 4.
      info.reject = (item.pio_modes[4:0] == 5'd0) ||
                    (item.pio_modes[15:5] != 11'd0) ||
                    ((item.udma_modes & ~udma_ok) != 16'h0000) ||
                    (item.mwdma_modes[15:3] != 13'd0) ||
                    ((item.mwdma_modes != 16'h0000) && (item.udma_modes != 16'h0000));

      info.pio_mode  = top_bit5(item.pio_modes[4:0]);
      info.dma_mode  = 2'(top_bit5({2'b00, item.mwdma_modes[2:0]}));
      info.udma_mode = top_bit5(item.udma_modes[4:0]);
      info.has_dma   = (item.mwdma_modes != 16'h0000);
      info.has_udma  = (item.udma_modes != 16'h0000);
   end

endmodule

`default_nettype wire

[design/ata_timing_register_select_top.sv]
// Configure item: decode step, a clamp and a scan of the PIO table (up to 11 entries) and,
// with multiword DMA, of the DMA table (up to 9) via one comparator, then the done step.
// Fetch item and rejected configure: a decode step, then the done step.
// The next item is accepted in the cycle after the result is registered.
// Synchronous active-high reset: 33 MHz cell, 40-conductor cable, both
// units hold the PIO mode 0 and multiword DMA mode 0 word.
// ----------------------------------------------------------------------------
// ata_timing_register_select_top
// Selects and stores per-unit ATA timing words and reads them back per command.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ata_timing_register_select_top #(
   parameter int NUM_UNITS = 2
) (
   input  logic             clock,
   input  logic             reset,
   // Request items.
   input  logic             req_valid,
   output logic             req_stall,
   input  ats_pkg::req_type req_item,
   // Result items.
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ats_pkg::rsp_type rsp_item,
   // Register writes.
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic             csr_data
);
   import ats_pkg::*;

   localparam int UNIT_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

   // Sequencer and configuration state.
   state_type   state_ff, state_in;
   logic        ultra_cell_ff, ultra_cell_in;
   logic        cable_80_ff, cable_80_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] words_ff [NUM_UNITS];
   logic [31:0] words_in [NUM_UNITS];

   // Item and work registers.
   req_type          item_ff, item_in;
   logic [15:0]      pio_t_ff, pio_t_in;
   logic [15:0]      dma_t_ff, dma_t_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] pi_ff, pi_in;
   logic [IDX_W-1:0] di_ff, di_in;
   rsp_type          rsp_ff, rsp_in;

   mode_info_type info;
   logic [15:0]   cmp_a;
   logic [15:0]   cmp_b;
   logic          cmp_le;
   logic          accept;
   logic          out_free;
   logic          csr_write;
   logic [UNIT_W-1:0] unit_sel;
   logic [31:0]   word_rd;
   logic [31:0]   pio_bits;
   logic [31:0]   dma_bits;
   logic [31:0]   cfg_word;

   ats_mode_check u_mode_check (
      .item       (item_ff),
      .ultra_cell (ultra_cell_ff),
      .cable_80   (cable_80_ff),
      .info       (info)
   );

   // The block takes one item at a time; it waits in IDLE for the next.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign unit_sel  = UNIT_W'(item_ff.unit);
   assign word_rd   = words_ff[unit_sel];

   // The one shared comparator: clamps and table scans all go through it.
   assign cmp_le = (cmp_a <= cmp_b);

   // Timing word of a configure item from the selected table entries.
   always_comb begin
      pio_bits = ultra_cell_ff ? PIO_BITS_66[pi_ff] : PIO_BITS_33[pi_ff];
      if (info.has_udma) begin
         dma_bits = UDMA_BITS_66[info.udma_mode];
      end else begin
         dma_bits = ultra_cell_ff ? DMA_BITS_66[di_ff] : DMA_BITS_33[di_ff];
      end
      cfg_word = pio_bits | dma_bits;
   end

   always_comb begin
      state_in      = state_ff;
      ultra_cell_in = ultra_cell_ff;
      cable_80_in   = cable_80_ff;
      rsp_valid_in  = rsp_valid_ff;
      item_in       = item_ff;
      pio_t_in      = pio_t_ff;
      dma_t_in      = dma_t_ff;
      idx_in        = idx_ff;
      pi_in         = pi_ff;
      di_in         = di_ff;
      rsp_in        = rsp_ff;
      cmp_a         = 16'h0000;
      cmp_b         = 16'h0000;
      for (int i = 0; i < NUM_UNITS; i++) begin
         words_in[i] = words_ff[i];
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes must come only while idle; the block does not enforce it.
      if (csr_write) begin
         case (csr_index)
            CSR_ULTRA_CELL: begin
               ultra_cell_in = csr_data;
               for (int i = 0; i < NUM_UNITS; i++) begin
                  words_in[i] = cell_word(csr_data);
               end
            end
            CSR_CABLE_80: begin
               cable_80_in = csr_data;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in  = req_item;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            // Without multiword DMA the DMA cycle reads as zero and, without
            // Ultra DMA either, the slowest DMA entry is used.
            dma_t_in = 16'h0000;
            di_in    = '0;
            if (item_ff.op == OP_FETCH || info.reject) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_PIO_CLAMP;
            end
         end
         ST_PIO_CLAMP: begin
            cmp_a    = item_ff.pio_cycle_ns;
            cmp_b    = PIO_MIN_NS[info.pio_mode];
            pio_t_in = cmp_le ? cmp_b : cmp_a;
            idx_in   = IDX_W'(PIO_ENTRIES - 1);
            state_in = ST_PIO_SCAN;
         end
         ST_PIO_SCAN: begin
            // Walk from the fastest entry toward the slowest; the first
            // entry that is not faster than asked wins.
            cmp_a = pio_t_ff;
            cmp_b = PIO_TIME[idx_ff];
            if (cmp_le || idx_ff == '0) begin
               pi_in    = idx_ff;
               state_in = info.has_dma ? ST_DMA_CLAMP : ST_DONE;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         ST_DMA_CLAMP: begin
            cmp_a    = item_ff.mwdma_cycle_ns;
            cmp_b    = DMA_MIN_NS[info.dma_mode];
            dma_t_in = cmp_le ? cmp_b : cmp_a;
            idx_in   = IDX_W'(DMA_ENTRIES - 1);
            state_in = ST_DMA_SCAN;
         end
         ST_DMA_SCAN: begin
            cmp_a = dma_t_ff;
            cmp_b = DMA_TIME[idx_ff];
            if (cmp_le || idx_ff == '0) begin
               di_in    = idx_ff;
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         ST_DONE: begin
            // Hold here until the result register is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               rsp_in       = '0;
               if (item_ff.op == OP_FETCH) begin
                  if (ultra_cell_ff && item_ff.dma_read && ((word_rd & ULTRA_BIT) != 32'h0)) begin
                     rsp_in.timing_word = word_rd + ULTRA_READ_ADJ;
                  end else begin
                     rsp_in.timing_word = word_rd;
                  end
               end else if (info.reject) begin
                  rsp_in.status = 1'b1;
               end else begin
                  rsp_in.timing_word    = cfg_word;
                  rsp_in.pio_cycle_used = pio_t_ff;
                  rsp_in.dma_cycle_used = dma_t_ff;
                  words_in[unit_sel]    = cfg_word;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ultra_cell_ff <= 1'b0;
         cable_80_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_UNITS; i++) begin
            words_ff[i] <= cell_word(1'b0);
         end
      end else begin
         state_ff      <= state_in;
         ultra_cell_ff <= ultra_cell_in;
         cable_80_ff   <= cable_80_in;
         rsp_valid_ff  <= rsp_valid_in;
         for (int i = 0; i < NUM_UNITS; i++) begin
            words_ff[i] <= words_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      pio_t_ff <= pio_t_in;
      dma_t_ff <= dma_t_in;
      idx_ff   <= idx_in;
      pi_ff    <= pi_in;
      di_ff    <= di_in;
      rsp_ff   <= rsp_in;
   end

   // An accepted item always starts with a decode step.
   `ATS_ASSERT(a_accept_decode, clock, reset, (accept |=> state_ff == ST_DECODE), "accepted item did not start decoding")

   // Leaving the final step always registers a result.
   `ATS_ASSERT(a_done_result, clock, reset, ((state_ff == ST_DONE && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE)), "finished item did not produce a result")

   // A rejected configure reports zeros in every other field.
   `ATS_ASSERT(a_reject_zero, clock, reset, ((rsp_valid_ff && rsp_ff.status) |-> (rsp_ff.timing_word == 32'h0 && rsp_ff.pio_cycle_used == 16'h0 && rsp_ff.dma_cycle_used == 16'h0)), "rejected result carries nonzero fields")

   // Neither table scan runs its index past the end of the PIO table.
   `ATS_ASSERT(a_scan_range, clock, reset, ((state_ff == ST_PIO_SCAN || state_ff == ST_DMA_SCAN) |-> (idx_ff < IDX_W'(PIO_ENTRIES))), "table scan index out of range")

endmodule

`default_nettype wire
